FILE: hw/rtl/gek_pkg.sv
// ----------------------------------------------------------------------------
// gek_pkg
// Shared constants, types and the arctangent table of the edge detector.
// ----------------------------------------------------------------------------
package gek_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CORDIC_STEPS  = 20;

  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd768;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
  } grad_t;

  // atan(2^-i) in units of pi/32768, 8 fraction bits
  function automatic logic signed [25:0] cordic_angle(input logic [4:0] idx);
    logic signed [25:0] a;
    case (idx)
      5'd0:  a = 26'sd2097152;
      5'd1:  a = 26'sd1238021;
      5'd2:  a = 26'sd654136;
      5'd3:  a = 26'sd332050;
      5'd4:  a = 26'sd166669;
      5'd5:  a = 26'sd83416;
      5'd6:  a = 26'sd41718;
      5'd7:  a = 26'sd20860;
      5'd8:  a = 26'sd10430;
      5'd9:  a = 26'sd5215;
      5'd10: a = 26'sd2608;
      5'd11: a = 26'sd1304;
      5'd12: a = 26'sd652;
      5'd13: a = 26'sd326;
      5'd14: a = 26'sd163;
      5'd15: a = 26'sd81;
      5'd16: a = 26'sd41;
      5'd17: a = 26'sd20;
      5'd18: a = 26'sd10;
      5'd19: a = 26'sd5;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/gek_line_mem.sv
// ----------------------------------------------------------------------------
// gek_line_mem
// Two line stores sharing a read address and a write address, registered read,
// read-before-write.
module gek_line_mem #(
  parameter int DEPTH = gek_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_above,
  output logic [7:0]    rd_two,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_above,
  input  logic [7:0]    wr_two
);

  logic [7:0] above_mem [DEPTH];
  logic [7:0] two_mem   [DEPTH];

  always_ff @(posedge clk) begin
    rd_above <= above_mem[rd_addr];
    rd_two   <= two_mem[rd_addr];
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
      two_mem[wr_addr]   <= wr_two;
    end
  end

endmodule

FILE: hw/rtl/gek_sqrt.sv
// ----------------------------------------------------------------------------
// gek_sqrt
// Gradient magnitude: squares, then digit-by-digit root with rounding.
// ----------------------------------------------------------------------------
module gek_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gek_pkg::grad_t grad,
  output logic          busy,
  output logic [10:0]   mag
);

  typedef enum logic [1:0] {Q_IDLE, Q_SUM, Q_ITER, Q_RND} q_state_t;

  q_state_t           state;
  logic [20:0]        sqx, sqy;
  logic [21:0]        op, res, one;
  logic [21:0]        trial;
  logic signed [21:0] px, py;

  assign px    = grad.gx * grad.gx;
  assign py    = grad.gy * grad.gy;
  assign trial = res + one;
  assign busy  = state != Q_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
    end else begin
      case (state)
        Q_IDLE: begin
          if (start) begin
            sqx   <= px[20:0];
            sqy   <= py[20:0];
            state <= Q_SUM;
          end
        end
        Q_SUM: begin
          op    <= {1'b0, sqx} + {1'b0, sqy};
          res   <= '0;
          one   <= 22'd1 << 20;
          state <= Q_ITER;
        end
        Q_ITER: begin
          if (op >= trial) begin
            op  <= op - trial;
            res <= (res >> 1) + one;
          end else begin
            res <= res >> 1;
          end
          one <= one >> 2;
          if (one == 22'd1) state <= Q_RND;
        end
        Q_RND: begin
          mag   <= (op > res) ? res[10:0] + 11'd1 : res[10:0];
          state <= Q_IDLE;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/gek_cordic.sv
// ----------------------------------------------------------------------------
// gek_cordic
// Gradient direction as a binary angle, vectoring CORDIC, one step a cycle.
// ----------------------------------------------------------------------------
module gek_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  gek_pkg::grad_t     grad,
  output logic               busy,
  output logic signed [15:0] dir
);

  typedef enum logic [1:0] {K_IDLE, K_RUN, K_FIN} k_state_t;

  k_state_t           state;
  logic signed [31:0] x, y, xe, ye, xs, ys;
  logic signed [25:0] z, zr;
  logic [4:0]         step;

  assign xe   = {{21{grad.gx[10]}}, grad.gx};
  assign ye   = {{21{grad.gy[10]}}, grad.gy};
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign zr   = z + 26'sd128;
  assign busy = state != K_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= K_IDLE;
    end else begin
      case (state)
        K_IDLE: begin
          if (start) begin
            step <= '0;
            if (ye == 0) begin
              dir <= (xe < 0) ? -16'sd32768 : 16'sd0;
            end else if (xe == 0) begin
              dir <= (ye > 0) ? 16'sd16384 : -16'sd16384;
            end else begin
              state <= K_RUN;
              if (xe < 0 && ye > 0) begin
                x <= ye <<< 16;
                y <= (-xe) <<< 16;
                z <= 26'sd4194304;
              end else if (xe < 0) begin
                x <= (-ye) <<< 16;
                y <= xe <<< 16;
                z <= -26'sd4194304;
              end else begin
                x <= xe <<< 16;
                y <= ye <<< 16;
                z <= '0;
              end
            end
          end
        end
        K_RUN: begin
          if (y >= 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + gek_pkg::cordic_angle(step);
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - gek_pkg::cordic_angle(step);
          end
          step <= step + 5'd1;
          if (step == 5'(gek_pkg::CORDIC_STEPS - 1)) state <= K_FIN;
        end
        K_FIN: begin
          dir   <= zr[23:8];
          state <= K_IDLE;
        end
        default: state <= K_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/gradient_edge_3x3_top.sv
// ----------------------------------------------------------------------------
// gradient_edge_3x3_top
// Streaming 3x3 Prewitt edge detector with line stores in memory.
// ----------------------------------------------------------------------------
// Takes one command beat at a time: a pixel beat reads both line stores at
// its column, updates the window and writes back, then computes zero, one
// or two results; a flush beat reads three columns and computes one result.
// Each result runs the magnitude root and the 20-step direction CORDIC side
// by side, the CORDIC being the longer of the two. The output register holds
// a result while the next is computed. Results lag one row; after the frame,
// one flush beat per column emits the last row, frame_last marking its final
// pixel.
// ----------------------------------------------------------------------------
module gradient_edge_3x3_top #(
  parameter int MAX_WIDTH = gek_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        row,
  output logic [AW-1:0]      col,
  output logic signed [10:0] grad_x,
  output logic signed [10:0] grad_y,
  output logic [10:0]        magnitude,
  output logic signed [15:0] direction,
  output logic               frame_last
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef logic [2:0][2:0][7:0] win_t;
  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PUPD, S_PJOB, S_FRD, S_FJOB, S_CALC, S_WAIT, S_OUT
  } state_t;

  function automatic gek_pkg::grad_t grad_of(input win_t w);
    logic [9:0] l, r, t, b;
    gek_pkg::grad_t g;
    l = 10'(w[0][0]) + 10'(w[1][0]) + 10'(w[2][0]);
    r = 10'(w[0][2]) + 10'(w[1][2]) + 10'(w[2][2]);
    t = 10'(w[0][0]) + 10'(w[0][1]) + 10'(w[0][2]);
    b = 10'(w[2][0]) + 10'(w[2][1]) + 10'(w[2][2]);
    g.gx = $signed({1'b0, r}) - $signed({1'b0, l});
    g.gy = $signed({1'b0, b}) - $signed({1'b0, t});
    return g;
  endfunction

  function automatic win_t shift_edge(input win_t w);
    win_t o;
    for (int i = 0; i < 3; i++) begin
      o[i][0] = w[i][1];
      o[i][1] = w[i][2];
      o[i][2] = w[i][2];
    end
    return o;
  endfunction

  state_t          state;
  logic [10:0]     frame_width;
  logic [12:0]     frame_height;
  logic [WW-1:0]   eff_w, in_col, flush_col, p_col, fcol0, fcol2, c_cur;
  logic [12:0]     eff_h, in_row, p_row, r_tmp, r_cur;
  logic            flush_pending;
  logic [7:0]      p_pix;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      rd_above, rd_two;
  win_t            window, win_new, fwin;
  logic [7:0]      f_la [3];
  logic [7:0]      f_lt [3];
  logic [7:0]      top_pix;
  logic [1:0]      rd_cnt, njobs;
  logic            jidx, e1, e2;
  gek_pkg::grad_t  job_g [2];
  gek_pkg::grad_t  gw, ge, gf;
  logic [11:0]     job_row [2];
  logic [AW-1:0]   job_col [2];
  logic            job_last [2];
  logic            sq_busy, co_busy;
  logic [10:0]     sq_mag;
  logic signed [15:0] co_dir;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;

  always_comb begin
    if (frame_width == 11'd0) eff_w = WW'(1);
    else if (int'(frame_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(frame_width);
    if (frame_height == 13'd0) eff_h = 13'd1;
    else if (int'(frame_height) > gek_pkg::MAX_HEIGHT) eff_h = 13'(gek_pkg::MAX_HEIGHT);
    else eff_h = frame_height;
  end

  assign c_cur = (in_col >= eff_w) ? '0 : in_col;
  assign r_tmp = (in_col >= eff_w) ? in_row + 13'd1 : in_row;
  assign r_cur = (r_tmp >= eff_h) ? '0 : r_tmp;
  assign fcol0 = (flush_col == '0) ? '0 : flush_col - WW'(1);
  assign fcol2 = (flush_col + WW'(1) >= eff_w) ? eff_w - WW'(1) : flush_col + WW'(1);

  assign top_pix = (p_row >= 13'd2) ? rd_two : rd_above;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwin[0][i] = (eff_h >= 13'd2) ? f_lt[i] : f_la[i];
      fwin[1][i] = f_la[i];
      fwin[2][i] = f_la[i];
    end
    if (p_col == '0) begin
      for (int i = 0; i < 3; i++) begin
        win_new[0][i] = top_pix;
        win_new[1][i] = rd_above;
        win_new[2][i] = p_pix;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        win_new[i][0] = window[i][1];
        win_new[i][1] = window[i][2];
      end
      win_new[0][2] = top_pix;
      win_new[1][2] = rd_above;
      win_new[2][2] = p_pix;
    end
  end

  assign gw = grad_of(window);
  assign ge = grad_of(shift_edge(window));
  assign gf = grad_of(fwin);
  assign e1 = (p_row >= 13'd1) && (p_col >= WW'(1));
  assign e2 = (p_row >= 13'd1) && (p_col == eff_w - WW'(1));

  gek_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem (
    .clk      (clk),
    .rd_addr  (mem_addr),
    .rd_above (rd_above),
    .rd_two   (rd_two),
    .wr_en    (state == S_PUPD),
    .wr_addr  (p_col[AW-1:0]),
    .wr_above (p_pix),
    .wr_two   (rd_above)
  );

  gek_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CALC),
    .grad  (job_g[jidx]),
    .busy  (sq_busy),
    .mag   (sq_mag)
  );

  gek_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CALC),
    .grad  (job_g[jidx]),
    .busy  (co_busy),
    .dir   (co_dir)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= gek_pkg::WIDTH_RESET;
      frame_height  <= gek_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gek_pkg::REG_FRAME_WIDTH) frame_width <= cfg_data[10:0];
      else if (cfg_index == gek_pkg::REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window        <= '0;
      in_col        <= '0;
      in_row        <= '0;
      flush_col     <= '0;
      flush_pending <= 1'b0;
      out_valid     <= 1'b0;
      rd_cnt        <= '0;
      njobs         <= '0;
      jidx          <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            p_pix <= pixel;
            if (cmd == gek_pkg::CMD_PIXEL) begin
              flush_pending <= 1'b0;
              flush_col     <= '0;
              p_col         <= c_cur;
              p_row         <= r_cur;
              mem_addr      <= c_cur[AW-1:0];
              state         <= S_PRD;
            end else if (flush_pending) begin
              if (flush_col >= eff_w) begin
                flush_pending <= 1'b0;
                flush_col     <= '0;
              end else begin
                mem_addr <= fcol0[AW-1:0];
                rd_cnt   <= '0;
                state    <= S_FRD;
              end
            end
          end
        end
        S_PRD: state <= S_PUPD;
        S_PUPD: begin
          window <= win_new;
          if (p_col + WW'(1) >= eff_w) begin
            in_col <= '0;
            if (p_row + 13'd1 >= eff_h) begin
              in_row        <= '0;
              flush_pending <= 1'b1;
              flush_col     <= '0;
            end else begin
              in_row <= p_row + 13'd1;
            end
          end else begin
            in_col <= p_col + WW'(1);
            in_row <= p_row;
          end
          state <= S_PJOB;
        end
        S_PJOB: begin
          job_row[0]  <= 12'(p_row - 13'd1);
          job_row[1]  <= 12'(p_row - 13'd1);
          job_last[0] <= 1'b0;
          job_last[1] <= 1'b0;
          job_g[1]    <= ge;
          job_col[1]  <= p_col[AW-1:0];
          if (e1) begin
            job_g[0]   <= gw;
            job_col[0] <= AW'(p_col - WW'(1));
          end else begin
            job_g[0]   <= ge;
            job_col[0] <= p_col[AW-1:0];
          end
          njobs <= {1'b0, e1} + {1'b0, e2};
          jidx  <= 1'b0;
          state <= (e1 || e2) ? S_CALC : S_IDLE;
        end
        S_FRD: begin
          rd_cnt <= rd_cnt + 2'd1;
          case (rd_cnt)
            2'd0: mem_addr <= flush_col[AW-1:0];
            2'd1: begin
              f_la[0]  <= rd_above;
              f_lt[0]  <= rd_two;
              mem_addr <= fcol2[AW-1:0];
            end
            2'd2: begin
              f_la[1] <= rd_above;
              f_lt[1] <= rd_two;
            end
            default: begin
              f_la[2] <= rd_above;
              f_lt[2] <= rd_two;
              state   <= S_FJOB;
            end
          endcase
        end
        S_FJOB: begin
          job_g[0]    <= gf;
          job_row[0]  <= 12'(eff_h - 13'd1);
          job_col[0]  <= flush_col[AW-1:0];
          job_last[0] <= flush_col == eff_w - WW'(1);
          if (flush_col + WW'(1) >= eff_w) begin
            flush_pending <= 1'b0;
            flush_col     <= '0;
          end else begin
            flush_col <= flush_col + WW'(1);
          end
          njobs <= 2'd1;
          jidx  <= 1'b0;
          state <= S_CALC;
        end
        S_CALC: state <= S_WAIT;
        S_WAIT: begin
          if (!sq_busy && !co_busy) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            row        <= job_row[jidx];
            col        <= job_col[jidx];
            grad_x     <= job_g[jidx].gx;
            grad_y     <= job_g[jidx].gy;
            magnitude  <= sq_mag;
            direction  <= co_dir;
            frame_last <= job_last[jidx];
            if ({1'b0, jidx} + 2'd1 < njobs) begin
              jidx  <= 1'b1;
              state <= S_CALC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pending_counters: assert property (@(posedge clk) disable iff (rst)
    flush_pending |-> (in_col == '0 && in_row == '0))
    else $error("flush pending with live input counters");

  a_pixel_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == gek_pkg::CMD_PIXEL) |=> state == S_PRD)
    else $error("pixel beat did not start a line store read");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result presented outside the output step");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (!sq_busy && !co_busy))
    else $error("result taken while a unit is still running");

endmodule
